[src/tcw_pkg.sv]
// shared constants, types and field widths of the text console writer
package tcw_pkg;

  // grid geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int SCROLL_LEN = CELL_COUNT - COLUMNS;
  localparam int LAST_CELL  = CELL_COUNT - 1;

  // internal widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);

  // field widths
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int OCOL_W     = 7;
  localparam int OROW_W     = 5;
  localparam int OFF_W      = 11;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ENABLE = 1'd1;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd15;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

[src/tcw_if.sv]
// command and result channel interfaces of the text console writer
interface tcw_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::OP_W-1:0]        op;
  logic [tcw_pkg::CHAR_W-1:0]      char_code;
  logic [tcw_pkg::RROW_W-1:0]      read_row;
  logic [tcw_pkg::RCOL_W-1:0]      read_col;

  modport source (output valid, op, char_code, read_row, read_col, input ready);
  modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcw_res_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::OCOL_W-1:0]      cursor_col;
  logic [tcw_pkg::OROW_W-1:0]      cursor_row;
  logic [tcw_pkg::OFF_W-1:0]       cursor_offset;
  logic                            cursor_update;
  logic [tcw_pkg::CHAR_W-1:0]      cell_char;
  logic [tcw_pkg::COLOR_W-1:0]     cell_color;

  modport source (output valid, cursor_col, cursor_row, cursor_offset, cursor_update,
                  cell_char, cell_color, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cursor_update,
                  cell_char, cell_color, output ready);
endinterface

[src/tcw_cell_ram.sv]
// simple dual-port ram, one write port and one registered read port
module tcw_cell_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/text_console_writer.sv]
// text console writer top level: cell grid sequencer around one cell ram
//
// Character-cell console. The grid (COLUMNS x ROWS cells, char in the low
// byte, attribute in the high byte) lives in one dual-port ram with a
// registered read port; the cursor lives in registers. Every command
// transaction gives exactly one result transaction. Commands are taken one
// at a time; a new command is taken while the previous result still waits
// in the output register. A read, a put of a printable byte and a newline
// without scroll each take the main step alone; a put that resolves a
// pending wrap without scroll takes it twice, moving the cursor down and
// then writing the byte; a newline or wrapped put on the last row scrolls
// through the ram one cell a cycle, then blanks the bottom row, and a
// wrapped put then writes its byte; a clear blanks every cell one a cycle,
// a pace set by the ram's single write port. After reset the block sweeps
// the ram with the reset attribute and takes no command meanwhile; register
// writes are taken at any time and must come only while the block is idle.
// A result that waits untaken holds off the next command's first step after
// acceptance, and also its final step when that comes later, as for a clear
// or a scroll.
module text_console_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  tcw_cmd_if.sink                         cmd_i,
  tcw_res_if.source                       res_o
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int CNT_W  = tcw_pkg::CNT_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;

  // sequencer and cursor state
  tcw_pkg::state_e                 state_q, state_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [COL_W-1:0]                col_q, col_d;
  logic [ROW_W-1:0]                row_q, row_d;
  logic [ADDR_W-1:0]               base_q, base_d;   // row * COLUMNS
  tcw_pkg::op_e                    op_q, op_d;
  logic [tcw_pkg::CHAR_W-1:0]      char_q, char_d;
  logic                            rd_ok_q, rd_ok_d;

  // configuration registers
  logic [tcw_pkg::COLOR_W-1:0]     color_q;
  logic                            cur_en_q;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic [tcw_pkg::OCOL_W-1:0]      out_col_q;
  logic [tcw_pkg::OROW_W-1:0]      out_row_q;
  logic [tcw_pkg::OFF_W-1:0]       out_off_q;
  logic                            out_upd_q;
  logic [tcw_pkg::CELL_W-1:0]      out_cell_q, out_cell_d;

  // ram ports
  logic                            mem_we, mem_re;
  logic [ADDR_W-1:0]               mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]      mem_wdata, mem_rdata;

  logic                            emit;
  logic                            slot_free;
  logic                            is_newline;
  logic [tcw_pkg::CELL_W-1:0]      blank_cell;
  logic [CNT_W-1:0]                offset_sum;

  assign slot_free  = !out_valid_q || res_o.ready;
  assign is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
  assign blank_cell = {color_q, {tcw_pkg::CHAR_W{1'b0}}};
  assign cmd_i.ready = (state_q == tcw_pkg::ST_IDLE);

  tcw_cell_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q  <= tcw_pkg::RESET_COLOR;
      cur_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tcw_pkg::CFG_TEXT_COLOR) begin
        color_q <= cfg_wdata_i;
      end else begin
        cur_en_q <= cfg_wdata_i[0];
      end
    end
  end

  // next state, ram control and cursor update
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    base_d     = base_q;
    op_d       = op_q;
    char_d     = char_q;
    rd_ok_d    = rd_ok_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    emit       = 1'b0;
    out_cell_d = '0;

    unique case (state_q)
      // sweep the reset attribute into every cell
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cnt_q);
        mem_wdata = {tcw_pkg::RESET_COLOR, {tcw_pkg::CHAR_W{1'b0}}};
        if (cnt_q == CNT_W'(tcw_pkg::LAST_CELL)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // take a command; a read issues its ram access right away
      tcw_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          op_d    = tcw_pkg::op_e'(cmd_i.op);
          char_d  = cmd_i.char_code;
          rd_ok_d = (32'(cmd_i.read_row) < tcw_pkg::ROWS) &&
                    (32'(cmd_i.read_col) < tcw_pkg::COLUMNS);
          mem_re    = (tcw_pkg::op_e'(cmd_i.op) == tcw_pkg::OP_READ);
          mem_raddr = ADDR_W'(32'(cmd_i.read_row) * tcw_pkg::COLUMNS +
                              32'(cmd_i.read_col));
          state_d = tcw_pkg::ST_EXEC;
        end
      end

      // main step, held until the result register can take the result
      tcw_pkg::ST_EXEC: begin
        if (slot_free) begin
          unique case (op_q)
            tcw_pkg::OP_PUT: begin
              if (is_newline || (col_q == COL_W'(tcw_pkg::COLUMNS))) begin
                col_d = '0;
                if (row_q < ROW_W'(tcw_pkg::ROWS - 1)) begin
                  row_d  = row_q + 1'b1;
                  base_d = base_q + ADDR_W'(tcw_pkg::COLUMNS);
                  if (is_newline) begin
                    emit    = 1'b1;
                    state_d = tcw_pkg::ST_IDLE;
                  end
                  // pending wrap resolved: write the byte next cycle
                end else begin
                  cnt_d   = '0;
                  state_d = tcw_pkg::ST_SCROLL;
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = base_q + ADDR_W'(col_q);
                mem_wdata = {color_q, char_q};
                col_d     = col_q + 1'b1;
                emit      = 1'b1;
                state_d   = tcw_pkg::ST_IDLE;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              base_d  = '0;
              cnt_d   = '0;
              state_d = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              if (rd_ok_q) begin
                out_cell_d = mem_rdata;
              end
              emit    = 1'b1;
              state_d = tcw_pkg::ST_IDLE;
            end
            default: begin
              // unused op: report the cursor only
              emit    = 1'b1;
              state_d = tcw_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // copy each cell one row up: read ahead, write each cell in the following cycle
      tcw_pkg::ST_SCROLL: begin
        if (cnt_q != CNT_W'(tcw_pkg::SCROLL_LEN)) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(cnt_q + CNT_W'(tcw_pkg::COLUMNS));
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = tcw_pkg::ST_FILL;   // count already points at the bottom row
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(cnt_q - 1'b1);
          mem_wdata = mem_rdata;
        end
      end

      // blank cells up to the end of the grid
      tcw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cnt_q);
        mem_wdata = blank_cell;
        if (cnt_q == CNT_W'(tcw_pkg::LAST_CELL)) begin
          cnt_d = '0;
          if ((op_q == tcw_pkg::OP_PUT) && !is_newline) begin
            state_d = tcw_pkg::ST_EXEC;   // wrapped put still has its byte to write
          end else begin
            state_d = tcw_pkg::ST_DONE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      tcw_pkg::ST_DONE: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  assign offset_sum = CNT_W'(base_d) + CNT_W'(col_d);

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      op_q        <= tcw_pkg::OP_PUT;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      op_q        <= op_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (emit) begin
      out_col_q  <= tcw_pkg::OCOL_W'(col_d);
      out_row_q  <= tcw_pkg::OROW_W'(row_d);
      out_off_q  <= tcw_pkg::OFF_W'(offset_sum);
      out_upd_q  <= cur_en_q &&
                    ((op_q == tcw_pkg::OP_PUT) || (op_q == tcw_pkg::OP_CLEAR));
      out_cell_q <= out_cell_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.cursor_col    = out_col_q;
  assign res_o.cursor_row    = out_row_q;
  assign res_o.cursor_offset = out_off_q;
  assign res_o.cursor_update = out_upd_q;
  assign res_o.cell_char     = out_cell_q[tcw_pkg::CHAR_W-1:0];
  assign res_o.cell_color    = out_cell_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];

`ifndef SYNTHESIS
  // the row base register tracks row times width
  a_base_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) == 32'(row_q) * tcw_pkg::COLUMNS)
    else $error("row base out of step with cursor row");

  // column never runs past the pending-wrap position
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) <= tcw_pkg::COLUMNS)
    else $error("cursor column beyond grid width");

  // nothing writes the ram while waiting for a command
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::ST_IDLE) |-> !mem_we)
    else $error("ram write while idle");

  // a new result only comes out of the final step of a command
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(state_q) == tcw_pkg::ST_EXEC) || ($past(state_q) == tcw_pkg::ST_DONE))
    else $error("result raised outside the final step");

  // an untaken result is never overwritten
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule
